### rtl/core/cir_pkg.sv
package cir_pkg;

  localparam int DEF_NUM_BODIES = 64;
  localparam int BODY_FIELD_W = 6;
  localparam int NUM_ATTRS = 8;
  localparam logic [15:0] TIMESTEP_RESET = 16'd1092;
  localparam int APB_AW = 3;
  localparam logic [APB_AW-1:0] ADDR_TIMESTEP = 3'd0;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_PEN = 2'd2;
  localparam logic [1:0] MODE_VEL = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_SAME = 2'd2;

  localparam logic [2:0] ATTR_POSX = 3'd0;
  localparam logic [2:0] ATTR_VELX = 3'd2;
  localparam logic [2:0] ATTR_ACCX = 3'd4;
  localparam logic [2:0] ATTR_IMASS = 3'd6;
  localparam logic [2:0] ATTR_BOUNCE = 3'd7;

  localparam logic signed [31:0] BOUNCE_MAX = 32'sd65536;

  typedef enum logic [2:0] {
    MS_DIFF_NX, MS_DIFF_NY, MS_Q_NX, MS_Q_NY,
    MS_ACC_TS, MS_NSEP_R, MS_R_ACC, MS_UPD
  } mul_sel_t;

  typedef enum logic [3:0] {
    D_NONE, D_IMA, D_IMB, D_DOT0, D_SEP, D_ACC, D_ACC_TS, D_NSV,
    D_NSV_ACC, D_R, D_DIV, D_SX, D_SY, D_UPD, D_WRIN, D_RDOUT
  } dest_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       item_attr;
    logic [2:0] attr;
    logic       use_b;
    logic       pa_ld;
    mul_sel_t   mul;
    dest_t      dest;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic same_body;
    logic total_zero;
    logic pen_nonpos;
    logic sep_pos;
    logic acc_neg;
    logic div_done;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

### rtl/core/cir_ifs.sv
interface cir_item_if;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [5:0]          body_a;
  logic [5:0]          body_b;
  logic [2:0]          attribute;
  logic signed [31:0]  value;
  logic signed [15:0]  normal_x;
  logic signed [15:0]  normal_y;
  logic signed [31:0]  penetration;

  modport source(output valid, mode, body_a, body_b, attribute, value, normal_x, normal_y,
                 penetration, input ready);
  modport sink(input valid, mode, body_a, body_b, attribute, value, normal_x, normal_y,
               penetration, output ready);
endinterface

interface cir_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic [1:0]         status;

  modport source(output valid, read_value, status, input ready);
  modport sink(input valid, read_value, status, output ready);
endinterface

### rtl/core/cir_div.sv
// Restoring divider, one quotient bit per cycle: q = sat((num << 16) / den).
module cir_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        num,
  input  logic [32:0]        den,
  output logic               done,
  output logic signed [31:0] q
);
  localparam int DW = 48;

  logic [DW-1:0] dvd;
  logic [DW-1:0] quo;
  logic [33:0]   rem;
  logic [32:0]   dsr;
  logic [5:0]    cnt;
  logic          busy;
  logic [33:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem[32:0], dvd[DW-1]};
  assign ge = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'(DW - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {num, 16'd0};
      dsr <= den;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DW-2:0], 1'b0};
      rem <= ge ? rem_sh - {1'b0, dsr} : rem_sh;
      quo <= {quo[DW-2:0], ge};
    end
  end

  assign q = (quo[DW-1:31] != '0) ? 32'sh7fffffff : signed'(quo[31:0]);
endmodule

### rtl/core/cir_datapath.sv
module cir_datapath #(
  parameter int NUM_BODIES = cir_pkg::DEF_NUM_BODIES
) (
  input  logic               clk,
  input  logic               rst,
  input  cir_pkg::cmd_t      cmd,
  output cir_pkg::stat_t     stat,
  input  logic [15:0]        timestep,
  input  logic [1:0]         mode,
  input  logic [5:0]         body_a,
  input  logic [5:0]         body_b,
  input  logic [2:0]         attribute,
  input  logic signed [31:0] value,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [31:0] penetration,
  output logic signed [31:0] read_value
);
  localparam int BW = $clog2(NUM_BODIES);
  localparam int AW = BW + 3;
  localparam int DEPTH = NUM_BODIES * cir_pkg::NUM_ATTRS;
  localparam int NIDX = 1 << cir_pkg::BODY_FIELD_W;

  logic [BW-1:0] body_map [NIDX];

  for (genvar g = 0; g < NIDX; g++) begin : g_map
    localparam int M = g % NUM_BODIES;
    assign body_map[g] = BW'(M);
  end

  logic [1:0]         mode_r;
  logic [BW-1:0]      ba, bb;
  logic [2:0]         attr_r;
  logic signed [31:0] value_r, pen;
  logic signed [15:0] nx, ny;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] mdata, pa;
  logic signed [31:0] ima, imb, sep, acc, nsv, sx, sy;
  logic [16:0]        r;
  logic signed [63:0] dacc;

  logic [AW-1:0]      addr;
  logic [2:0]         attr_sel;
  logic signed [31:0] wdata;

  logic signed [32:0] diff;
  logic signed [33:0] ma, mag_a;
  logic signed [32:0] mb, mag_b;
  logic [64:0]        p_full;
  logic [63:0]        prod, shifted;
  logic               neg_r, sh16_r, sh16;
  logic signed [63:0] mres;
  logic signed [31:0] s_k, im_k, mres_sat, t_nsv, dv;
  logic [32:0]        total;

  logic               div_done;
  logic signed [31:0] q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      ba <= body_map[body_a];
      bb <= body_map[body_b];
      attr_r <= attribute;
      value_r <= value;
      nx <= normal_x;
      ny <= normal_y;
      pen <= penetration;
    end
  end

  assign attr_sel = cmd.item_attr ? attr_r : cmd.attr;
  assign addr = {(cmd.use_b ? bb : ba), attr_sel};
  assign total = {1'b0, ima} + {1'b0, imb};
  assign diff = {pa[31], pa} - {mdata[31], mdata};
  assign s_k = cmd.k[0] ? sy : sx;
  assign im_k = cmd.k[1] ? imb : ima;

  always_comb begin
    ma = '0;
    mb = '0;
    sh16 = 1'b1;
    unique case (cmd.mul)
      cir_pkg::MS_DIFF_NX: begin
        ma = {diff[32], diff};
        mb = 33'(nx);
        sh16 = 1'b0;
      end
      cir_pkg::MS_DIFF_NY: begin
        ma = {diff[32], diff};
        mb = 33'(ny);
        sh16 = 1'b0;
      end
      cir_pkg::MS_Q_NX: begin
        ma = 34'(q);
        mb = 33'(nx);
        sh16 = 1'b0;
      end
      cir_pkg::MS_Q_NY: begin
        ma = 34'(q);
        mb = 33'(ny);
        sh16 = 1'b0;
      end
      cir_pkg::MS_ACC_TS: begin
        ma = 34'(acc);
        mb = {17'd0, timestep};
      end
      cir_pkg::MS_NSEP_R: begin
        ma = -34'(sep);
        mb = {16'd0, r};
      end
      cir_pkg::MS_R_ACC: begin
        ma = {17'd0, r};
        mb = 33'(acc);
      end
      cir_pkg::MS_UPD: begin
        ma = 34'(s_k);
        mb = 33'(im_k);
      end
      default: ;
    endcase
  end

  // Sign and magnitude: the product is truncated toward zero after the shift.
  assign mag_a = ma[33] ? -ma : ma;
  assign mag_b = mb[32] ? -mb : mb;
  assign p_full = mag_a[32:0] * mag_b[31:0];

  always_ff @(posedge clk) begin
    prod <= p_full[63:0];
    neg_r <= ma[33] ^ mb[32];
    sh16_r <= sh16;
  end

  assign shifted = sh16_r ? (prod >> 16) : (prod >> 14);
  assign mres = neg_r ? -signed'(shifted) : signed'(shifted);
  assign mres_sat = cir_pkg::sat32(mres);
  assign t_nsv = cir_pkg::sat32(64'(nsv) + mres);
  assign dv = cir_pkg::sat32(64'(nsv) - 64'(sep));

  always_comb begin
    wdata = cmd.k[1] ? cir_pkg::sat32(64'(mdata) - 64'(mres_sat))
                     : cir_pkg::sat32(64'(mdata) + 64'(mres_sat));
    if (cmd.dest == cir_pkg::D_WRIN) begin
      wdata = value_r;
      if (attr_r == cir_pkg::ATTR_IMASS && value_r < 0) wdata = '0;
      if (attr_r == cir_pkg::ATTR_BOUNCE) begin
        if (value_r < 0) wdata = '0;
        else if (value_r > cir_pkg::BOUNCE_MAX) wdata = cir_pkg::BOUNCE_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dest == cir_pkg::D_UPD || cmd.dest == cir_pkg::D_WRIN) mem[addr] <= wdata;
    if (cmd.rd_en) mdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.pa_ld) pa <= mdata;
    if (cmd.load) read_value <= '0;
    case (cmd.dest)
      cir_pkg::D_IMA:     ima <= mdata;
      cir_pkg::D_IMB:     imb <= mdata;
      cir_pkg::D_DOT0:    dacc <= mres;
      cir_pkg::D_SEP:     sep <= cir_pkg::sat32(dacc + mres);
      cir_pkg::D_ACC:     acc <= cir_pkg::sat32(dacc + mres);
      cir_pkg::D_ACC_TS:  acc <= mres_sat;
      cir_pkg::D_NSV:     nsv <= mres_sat;
      cir_pkg::D_NSV_ACC: nsv <= (t_nsv < 0) ? '0 : t_nsv;
      cir_pkg::D_R:       r <= (pa < mdata) ? pa[16:0] : mdata[16:0];
      cir_pkg::D_SX:      sx <= mres_sat;
      cir_pkg::D_SY:      sy <= mres_sat;
      cir_pkg::D_RDOUT:   read_value <= mdata;
      default: ;
    endcase
  end

  cir_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.dest == cir_pkg::D_DIV),
    .num   (mode_r == cir_pkg::MODE_VEL ? dv : pen),
    .den   (total),
    .done  (div_done),
    .q     (q)
  );

  assign stat.same_body = ba == bb;
  assign stat.total_zero = total == '0;
  assign stat.pen_nonpos = pen <= 0;
  assign stat.sep_pos = sep > 0;
  assign stat.acc_neg = acc < 0;
  assign stat.div_done = div_done;
endmodule

### rtl/core/cir_ctrl.sv
module cir_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_mode,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output cir_pkg::cmd_t  cmd,
  input  cir_pkg::stat_t stat
);
  typedef enum logic [32:0] {
    S_IDLE = 33'd1 << 0,  S_DISP = 33'd1 << 1,  S_WR = 33'd1 << 2,
    S_RD = 33'd1 << 3,    S_RDL = 33'd1 << 4,   S_IMA = 33'd1 << 5,
    S_IMB = 33'd1 << 6,   S_IML = 33'd1 << 7,   S_CHK = 33'd1 << 8,
    S_D0 = 33'd1 << 9,    S_D1 = 33'd1 << 10,   S_D2 = 33'd1 << 11,
    S_D3 = 33'd1 << 12,   S_D4 = 33'd1 << 13,   S_D5 = 33'd1 << 14,
    S_VCHK = 33'd1 << 15, S_BR0 = 33'd1 << 16,  S_BR1 = 33'd1 << 17,
    S_BR2 = 33'd1 << 18,  S_M1 = 33'd1 << 19,   S_M2 = 33'd1 << 20,
    S_M3 = 33'd1 << 21,   S_DIV = 33'd1 << 22,  S_DIVW = 33'd1 << 23,
    S_Q0 = 33'd1 << 24,   S_Q1 = 33'd1 << 25,   S_Q2 = 33'd1 << 26,
    S_U0 = 33'd1 << 27,   S_U1 = 33'd1 << 28,   S_OUT = 33'd1 << 29,
    S_SPARE0 = 33'd1 << 30, S_SPARE1 = 33'd1 << 31, S_SPARE2 = 33'd1 << 32
  } state_t;

  state_t     state, state_next;
  logic [1:0] mode, status_next, k, k_next;
  logic       dot_acc, dot_acc_next;
  logic [2:0] dbase, ubase;

  assign dbase = dot_acc ? cir_pkg::ATTR_ACCX : cir_pkg::ATTR_VELX;
  assign ubase = (mode == cir_pkg::MODE_VEL) ? cir_pkg::ATTR_VELX : cir_pkg::ATTR_POSX;
  assign in_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      status <= cir_pkg::ST_DONE;
      k <= '0;
      dot_acc <= 1'b0;
      mode <= cir_pkg::MODE_WRITE;
    end else begin
      state <= state_next;
      status <= status_next;
      k <= k_next;
      dot_acc <= dot_acc_next;
      if (in_valid && in_ready) mode <= in_mode;
    end
  end

  always_comb begin
    state_next = state;
    status_next = status;
    k_next = k;
    dot_acc_next = dot_acc;
    cmd = '0;
    cmd.mul = cir_pkg::MS_DIFF_NX;
    cmd.dest = cir_pkg::D_NONE;
    cmd.k = k;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        status_next = cir_pkg::ST_DONE;
        state_next = S_DISP;
      end
      S_DISP: begin
        if (mode == cir_pkg::MODE_WRITE) state_next = S_WR;
        else if (mode == cir_pkg::MODE_READ) state_next = S_RD;
        else if (stat.same_body) begin
          status_next = cir_pkg::ST_SAME;
          state_next = S_OUT;
        end else state_next = S_IMA;
      end
      S_WR: begin
        cmd.item_attr = 1'b1;
        cmd.dest = cir_pkg::D_WRIN;
        state_next = S_OUT;
      end
      S_RD: begin
        cmd.item_attr = 1'b1;
        cmd.rd_en = 1'b1;
        state_next = S_RDL;
      end
      S_RDL: begin
        cmd.dest = cir_pkg::D_RDOUT;
        state_next = S_OUT;
      end
      S_IMA: begin
        cmd.rd_en = 1'b1;
        cmd.attr = cir_pkg::ATTR_IMASS;
        state_next = S_IMB;
      end
      S_IMB: begin
        cmd.rd_en = 1'b1;
        cmd.attr = cir_pkg::ATTR_IMASS;
        cmd.use_b = 1'b1;
        cmd.dest = cir_pkg::D_IMA;
        state_next = S_IML;
      end
      S_IML: begin
        cmd.dest = cir_pkg::D_IMB;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (mode == cir_pkg::MODE_PEN) begin
          if (stat.pen_nonpos || stat.total_zero) begin
            status_next = cir_pkg::ST_SKIP;
            state_next = S_OUT;
          end else state_next = S_DIV;
        end else begin
          dot_acc_next = 1'b0;
          state_next = S_D0;
        end
      end
      // Relative vector of body a minus body b, dotted with the normal.
      S_D0: begin
        cmd.rd_en = 1'b1;
        cmd.attr = dbase;
        state_next = S_D1;
      end
      S_D1: begin
        cmd.rd_en = 1'b1;
        cmd.attr = dbase;
        cmd.use_b = 1'b1;
        cmd.pa_ld = 1'b1;
        state_next = S_D2;
      end
      S_D2: begin
        cmd.rd_en = 1'b1;
        cmd.attr = dbase + 3'd1;
        cmd.mul = cir_pkg::MS_DIFF_NX;
        state_next = S_D3;
      end
      S_D3: begin
        cmd.rd_en = 1'b1;
        cmd.attr = dbase + 3'd1;
        cmd.use_b = 1'b1;
        cmd.pa_ld = 1'b1;
        cmd.dest = cir_pkg::D_DOT0;
        state_next = S_D4;
      end
      S_D4: begin
        cmd.mul = cir_pkg::MS_DIFF_NY;
        state_next = S_D5;
      end
      S_D5: begin
        cmd.dest = dot_acc ? cir_pkg::D_ACC : cir_pkg::D_SEP;
        state_next = dot_acc ? S_BR0 : S_VCHK;
      end
      S_VCHK: begin
        if (stat.sep_pos || stat.total_zero) begin
          status_next = cir_pkg::ST_SKIP;
          state_next = S_OUT;
        end else begin
          dot_acc_next = 1'b1;
          state_next = S_D0;
        end
      end
      S_BR0: begin
        cmd.rd_en = 1'b1;
        cmd.attr = cir_pkg::ATTR_BOUNCE;
        state_next = S_BR1;
      end
      S_BR1: begin
        cmd.rd_en = 1'b1;
        cmd.attr = cir_pkg::ATTR_BOUNCE;
        cmd.use_b = 1'b1;
        cmd.pa_ld = 1'b1;
        state_next = S_BR2;
      end
      S_BR2: begin
        cmd.dest = cir_pkg::D_R;
        cmd.mul = cir_pkg::MS_ACC_TS;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.dest = cir_pkg::D_ACC_TS;
        cmd.mul = cir_pkg::MS_NSEP_R;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.dest = cir_pkg::D_NSV;
        cmd.mul = cir_pkg::MS_R_ACC;
        state_next = S_M3;
      end
      S_M3: begin
        if (stat.acc_neg) cmd.dest = cir_pkg::D_NSV_ACC;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.dest = cir_pkg::D_DIV;
        state_next = S_DIVW;
      end
      S_DIVW: if (stat.div_done) state_next = S_Q0;
      S_Q0: begin
        cmd.mul = cir_pkg::MS_Q_NX;
        state_next = S_Q1;
      end
      S_Q1: begin
        cmd.mul = cir_pkg::MS_Q_NY;
        cmd.dest = cir_pkg::D_SX;
        state_next = S_Q2;
      end
      S_Q2: begin
        cmd.dest = cir_pkg::D_SY;
        k_next = '0;
        state_next = S_U0;
      end
      // k: bit 0 picks the y component, bit 1 picks body b.
      S_U0: begin
        cmd.rd_en = 1'b1;
        cmd.attr = ubase + {2'd0, k[0]};
        cmd.use_b = k[1];
        cmd.mul = cir_pkg::MS_UPD;
        state_next = S_U1;
      end
      S_U1: begin
        cmd.attr = ubase + {2'd0, k[0]};
        cmd.use_b = k[1];
        cmd.dest = cir_pkg::D_UPD;
        k_next = k + 2'd1;
        state_next = (k == 2'd3) ? S_OUT : S_U0;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### rtl/core/contact_impulse_resolver.sv
// Contact impulse resolver: a table of 2D rigid bodies in Q16.16 held in a single-port
// memory, with a sequencer that handles one transaction at a time. A contact that goes
// through to the update takes longer than a write or a read, set by the bit-serial
// divider and by the one memory read per cycle that feeds the shared multiplier.
// Skipped contacts finish early. The timestep register sits at byte address 0 of the
// APB port.
module contact_impulse_resolver #(
  parameter int NUM_BODIES = cir_pkg::DEF_NUM_BODIES
) (
  input  logic                        clk,
  input  logic                        rst,
  cir_item_if.sink                    item,
  cir_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cir_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  cir_pkg::cmd_t  cmd;
  cir_pkg::stat_t stat;
  logic [15:0]    timestep;

  assign pready = 1'b1;
  assign prdata = (paddr == cir_pkg::ADDR_TIMESTEP) ? {16'd0, timestep} : '0;

  always_ff @(posedge clk) begin
    if (rst) timestep <= cir_pkg::TIMESTEP_RESET;
    else if (psel && penable && pwrite && pready && paddr == cir_pkg::ADDR_TIMESTEP)
      timestep <= pwdata[15:0];
  end

  cir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_mode   (item.mode),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (result.status),
    .cmd       (cmd),
    .stat      (stat)
  );

  cir_datapath #(.NUM_BODIES(NUM_BODIES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .timestep    (timestep),
    .mode        (item.mode),
    .body_a      (item.body_a),
    .body_b      (item.body_b),
    .attribute   (item.attribute),
    .value       (item.value),
    .normal_x    (item.normal_x),
    .normal_y    (item.normal_y),
    .penetration (item.penetration),
    .read_value  (result.read_value)
  );
endmodule

### rtl/core/cir_checker.sv
module cir_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic [1:0]  item_mode,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result_read_value,
  input logic [1:0]  result_status
);
  logic [1:0] last_mode;
  logic       pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      last_mode <= cir_pkg::MODE_WRITE;
    end else begin
      if (item_valid && item_ready) begin
        pending <= 1'b1;
        last_mode <= item_mode;
      end else if (result_valid && result_ready) pending <= 1'b0;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before its transaction completed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready)
    else $error("input taken while a result is outstanding");

  a_matched: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending)
    else $error("result with no accepted item behind it");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_mode != cir_pkg::MODE_READ |-> result_read_value == '0)
    else $error("read_value not zero outside a read");

  a_same_contact: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_status == cir_pkg::ST_SAME
      |-> (last_mode == cir_pkg::MODE_PEN || last_mode == cir_pkg::MODE_VEL))
    else $error("same-body status on a non-contact item");
endmodule

bind contact_impulse_resolver cir_checker u_chk (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .item_mode         (item.mode),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_read_value (result.read_value),
  .result_status     (result.status)
);

### tb/tb_contact_impulse_resolver.sv
`timescale 1ns / 100ps

module tb_contact_impulse_resolver;

  localparam logic [2:0] ATTR_POSY = 3'd1;
  localparam logic [2:0] ATTR_VELY = 3'd3;
  localparam logic [2:0] ATTR_ACCY = 3'd5;
  localparam int NBODY = cir_pkg::DEF_NUM_BODIES;

  typedef struct {
    logic [1:0]         mode;
    logic [5:0]         a;
    logic [5:0]         b;
    logic [2:0]         attr;
    logic signed [31:0] value;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [31:0] pen;
  } body_op_t;

  typedef struct {
    logic [31:0] rd;
    logic [1:0]  st;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [cir_pkg::APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  cir_item_if item_ch();
  cir_result_if res_ch();

  contact_impulse_resolver dut (
    .clk(clk), .rst(rst), .item(item_ch), .result(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted body table, indexed by attribute then body.
  longint body_tab[cir_pkg::NUM_ATTRS][NBODY];
  bit [15:0] step_q016 = cir_pkg::TIMESTEP_RESET;
  bit known[NBODY][cir_pkg::NUM_ATTRS];
  int full_bodies[$];

  body_op_t pending_ops[$];
  outcome_t outcomes_due[$];
  int errors = 0;
  int results_seen = 0;
  int mode_cnt[4];
  int status_cnt[4];

  int snd_gap_max = 3;
  int rcv_gap_max = 3;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Exact product of magnitudes, shifted back and truncated toward zero.
  function automatic longint mul_shift(longint x, longint y, int sh);
    bit neg = (x < 0) != (y < 0);
    bit [63:0] ux = x < 0 ? -x : x;
    bit [63:0] uy = y < 0 ? -y : y;
    bit [63:0] m = (ux * uy) >> sh;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_q16(longint num, longint den);
    bit [63:0] q = (64'(num) << 16) / 64'(den);
    return clamp32(longint'(q));
  endfunction

  function automatic longint dot_n(longint x, longint y, longint nx, longint ny);
    return clamp32(mul_shift(x, nx, 14) + mul_shift(y, ny, 14));
  endfunction

  task automatic apply_op(input body_op_t op, output outcome_t res);
    int a, b;
    longint value, nx, ny, pen, total, mv, sx, sy, sep, acc, r, nsv, dv, imp, ix, iy;
    a = op.a % NBODY;
    b = op.b % NBODY;
    value = longint'(op.value);
    nx = longint'(op.nx);
    ny = longint'(op.ny);
    pen = longint'(op.pen);
    res.rd = '0;
    res.st = cir_pkg::ST_DONE;
    total = body_tab[cir_pkg::ATTR_IMASS][a] + body_tab[cir_pkg::ATTR_IMASS][b];
    if (op.mode == cir_pkg::MODE_WRITE) begin
      if (op.attr == cir_pkg::ATTR_IMASS && value < 0) value = 0;
      if (op.attr == cir_pkg::ATTR_BOUNCE)
        value = value < 0 ? 0 :
                (value > cir_pkg::BOUNCE_MAX ? cir_pkg::BOUNCE_MAX : value);
      body_tab[op.attr][a] = value;
    end else if (op.mode == cir_pkg::MODE_READ) begin
      res.rd = body_tab[op.attr][a][31:0];
    end else if (a == b) begin
      res.st = cir_pkg::ST_SAME;
    end else if (op.mode == cir_pkg::MODE_PEN) begin
      if (pen <= 0 || total <= 0) begin
        res.st = cir_pkg::ST_SKIP;
      end else begin
        mv = div_q16(pen, total);
        sx = clamp32(mul_shift(mv, nx, 14));
        sy = clamp32(mul_shift(mv, ny, 14));
        body_tab[cir_pkg::ATTR_POSX][a] = clamp32(body_tab[cir_pkg::ATTR_POSX][a]
            + clamp32(mul_shift(sx, body_tab[cir_pkg::ATTR_IMASS][a], 16)));
        body_tab[ATTR_POSY][a] = clamp32(body_tab[ATTR_POSY][a]
            + clamp32(mul_shift(sy, body_tab[cir_pkg::ATTR_IMASS][a], 16)));
        body_tab[cir_pkg::ATTR_POSX][b] = clamp32(body_tab[cir_pkg::ATTR_POSX][b]
            - clamp32(mul_shift(sx, body_tab[cir_pkg::ATTR_IMASS][b], 16)));
        body_tab[ATTR_POSY][b] = clamp32(body_tab[ATTR_POSY][b]
            - clamp32(mul_shift(sy, body_tab[cir_pkg::ATTR_IMASS][b], 16)));
      end
    end else begin
      sep = dot_n(body_tab[cir_pkg::ATTR_VELX][a] - body_tab[cir_pkg::ATTR_VELX][b],
                  body_tab[ATTR_VELY][a] - body_tab[ATTR_VELY][b], nx, ny);
      if (sep > 0 || total <= 0) begin
        res.st = cir_pkg::ST_SKIP;
      end else begin
        acc = dot_n(body_tab[cir_pkg::ATTR_ACCX][a] - body_tab[cir_pkg::ATTR_ACCX][b],
                    body_tab[ATTR_ACCY][a] - body_tab[ATTR_ACCY][b], nx, ny);
        r = body_tab[cir_pkg::ATTR_BOUNCE][a] < body_tab[cir_pkg::ATTR_BOUNCE][b] ?
            body_tab[cir_pkg::ATTR_BOUNCE][a] : body_tab[cir_pkg::ATTR_BOUNCE][b];
        acc = clamp32(mul_shift(acc, longint'(step_q016), 16));
        nsv = clamp32(mul_shift(-sep, r, 16));
        // Only an acceleration that pushes the bodies together is removed.
        if (acc < 0) begin
          nsv = clamp32(nsv + mul_shift(r, acc, 16));
          if (nsv < 0) nsv = 0;
        end
        dv = clamp32(nsv - sep);
        imp = div_q16(dv, total);
        ix = clamp32(mul_shift(imp, nx, 14));
        iy = clamp32(mul_shift(imp, ny, 14));
        body_tab[cir_pkg::ATTR_VELX][a] = clamp32(body_tab[cir_pkg::ATTR_VELX][a]
            + clamp32(mul_shift(ix, body_tab[cir_pkg::ATTR_IMASS][a], 16)));
        body_tab[ATTR_VELY][a] = clamp32(body_tab[ATTR_VELY][a]
            + clamp32(mul_shift(iy, body_tab[cir_pkg::ATTR_IMASS][a], 16)));
        body_tab[cir_pkg::ATTR_VELX][b] = clamp32(body_tab[cir_pkg::ATTR_VELX][b]
            - clamp32(mul_shift(ix, body_tab[cir_pkg::ATTR_IMASS][b], 16)));
        body_tab[ATTR_VELY][b] = clamp32(body_tab[ATTR_VELY][b]
            - clamp32(mul_shift(iy, body_tab[cir_pkg::ATTR_IMASS][b], 16)));
      end
    end
  endtask

  // ---------------- stimulus generation ----------------

  function automatic logic signed [31:0] pick_value(logic [2:0] attr);
    int sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    if (sel == 1) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    if (attr == cir_pkg::ATTR_IMASS) return sel == 2 ? -$urandom_range(1, 5000) :
                                   (sel == 3 ? 0 : $urandom_range(0, 32'h30000));
    if (attr == cir_pkg::ATTR_BOUNCE) return $signed($urandom_range(0, 150000)) - 20000;
    return $signed($urandom_range(0, 32'h200000)) - 32'sh100000;
  endfunction

  function automatic logic signed [15:0] pick_normal();
    int sel = $urandom_range(0, 9);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
  endfunction

  function automatic logic signed [31:0] pick_depth();
    int sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    if (sel == 1) return -$signed($urandom_range(0, 32'h40000));
    return $urandom_range(1, 32'h40000);
  endfunction

  task automatic push_op(input body_op_t op);
    int i;
    int was_full;
    if (op.mode == cir_pkg::MODE_WRITE) begin
      was_full = 1;
      for (i = 0; i < cir_pkg::NUM_ATTRS; i++) if (!known[op.a][i]) was_full = 0;
      known[op.a][op.attr] = 1;
      if (!was_full) begin
        was_full = 1;
        for (i = 0; i < cir_pkg::NUM_ATTRS; i++) if (!known[op.a][i]) was_full = 0;
        if (was_full) full_bodies.push_back(op.a);
      end
    end
    pending_ops.push_back(op);
  endtask

  task automatic put_attr(input int a, input logic [2:0] attr, input logic signed [31:0] v);
    body_op_t op;
    op = '{cir_pkg::MODE_WRITE, 6'(a), 6'($urandom), attr, v, 16'($urandom),
           16'($urandom), $urandom};
    push_op(op);
  endtask

  task automatic get_attr(input int a, input logic [2:0] attr);
    body_op_t op;
    op = '{cir_pkg::MODE_READ, 6'(a), 6'($urandom), attr, $urandom, 16'($urandom),
           16'($urandom), $urandom};
    push_op(op);
  endtask

  task automatic contact(input logic [1:0] m, input int a, input int b,
                         input logic signed [15:0] nx, input logic signed [15:0] ny,
                         input logic signed [31:0] pen);
    body_op_t op;
    op = '{m, 6'(a), 6'(b), 3'($urandom), $urandom, nx, ny, pen};
    push_op(op);
  endtask

  task automatic random_op();
    int a, b, k;
    logic [2:0] attr;
    k = $urandom_range(0, 99);
    a = $urandom_range(0, NBODY - 1);
    attr = 3'($urandom);
    if (k < 25 || (k < 40 && !known[a][attr])) begin
      put_attr(a, attr, pick_value(attr));
    end else if (k < 40) begin
      get_attr(a, attr);
    end else begin
      a = full_bodies[$urandom_range(0, full_bodies.size() - 1)];
      b = full_bodies[$urandom_range(0, full_bodies.size() - 1)];
      contact(k < 68 ? cir_pkg::MODE_PEN : cir_pkg::MODE_VEL, a, b, pick_normal(),
              pick_normal(), pick_depth());
    end
  endtask

  task automatic setup_body(input int a, input bit no_mass);
    int i;
    for (i = 0; i < cir_pkg::NUM_ATTRS; i++)
      put_attr(a, 3'(i), (no_mass && 3'(i) == cir_pkg::ATTR_IMASS) ? 32'sd0
                                                                   : pick_value(3'(i)));
  endtask

  // ---------------- driver ----------------

  bit offering = 0;
  body_op_t cur_op;
  int snd_wait = 0;

  always @(posedge clk) begin
    outcome_t res;
    if (rst) begin
      offering = 0;
      item_ch.valid <= 1'b0;
    end else begin
      if (offering && item_ch.ready) begin
        apply_op(cur_op, res);
        outcomes_due.push_back(res);
        mode_cnt[cur_op.mode]++;
        status_cnt[res.st]++;
        offering = 0;
        snd_wait = $urandom_range(0, snd_gap_max);
      end
      if (!offering) begin
        if (snd_wait > 0) snd_wait--;
        else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          offering = 1;
        end
      end
      item_ch.valid <= offering;
      item_ch.mode <= cur_op.mode;
      item_ch.body_a <= cur_op.a;
      item_ch.body_b <= cur_op.b;
      item_ch.attribute <= cur_op.attr;
      item_ch.value <= cur_op.value;
      item_ch.normal_x <= cur_op.nx;
      item_ch.normal_y <= cur_op.ny;
      item_ch.penetration <= cur_op.pen;
    end
  end

  // ---------------- monitor ----------------

  int rcv_wait = 0;
  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (outcomes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result read_value=%h status=%0d", $time,
                   res_ch.read_value, res_ch.status);
        end else begin
          want = outcomes_due.pop_front();
          if (res_ch.read_value !== want.rd) begin
            errors++;
            $display("%0t: read_value expected %h actual %h", $time, want.rd,
                     res_ch.read_value);
          end
          if (res_ch.status !== want.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, res_ch.status);
          end
        end
        rcv_wait = $urandom_range(0, rcv_gap_max);
        // One long back-pressure stretch so that the input side has to stall.
        if (!hold_done && results_seen == 700) begin
          hold_done = 1;
          hold_left = 400;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (rcv_wait > 0) begin
        rcv_wait--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- sequence ----------------

  task automatic wait_idle();
    while (pending_ops.size() > 0 || offering || outcomes_due.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_timestep(input logic [15:0] ts);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= cir_pkg::ADDR_TIMESTEP;
    pwdata <= {16'd0, ts};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    step_q016 = ts;
  endtask

  initial begin
    int i, p;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.mode = cir_pkg::MODE_WRITE;
    item_ch.body_a = '0;
    item_ch.body_b = '0;
    item_ch.attribute = '0;
    item_ch.value = '0;
    item_ch.normal_x = '0;
    item_ch.normal_y = '0;
    item_ch.penetration = '0;
    res_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 8; i++) setup_body(i, 0);
    setup_body(62, 1);
    setup_body(63, 1);

    // Directed: saturating writes, clamps, each skip reason and extreme normals.
    put_attr(0, cir_pkg::ATTR_POSX, 32'sh7fffffff);
    put_attr(0, ATTR_POSY, 32'sh80000000);
    put_attr(1, cir_pkg::ATTR_IMASS, -32'sd7);
    put_attr(2, cir_pkg::ATTR_BOUNCE, 32'sd70000);
    put_attr(3, cir_pkg::ATTR_BOUNCE, -32'sd5);
    put_attr(4, cir_pkg::ATTR_IMASS, 32'sh10000);
    get_attr(0, cir_pkg::ATTR_POSX);
    get_attr(0, ATTR_POSY);
    get_attr(1, cir_pkg::ATTR_IMASS);
    get_attr(2, cir_pkg::ATTR_BOUNCE);
    get_attr(3, cir_pkg::ATTR_BOUNCE);
    contact(cir_pkg::MODE_PEN, 5, 5, 16'sd16384, 16'sd0, 32'sd65536);
    contact(cir_pkg::MODE_VEL, 6, 6, 16'sd0, 16'sd16384, 32'sd0);
    contact(cir_pkg::MODE_PEN, 4, 5, 16'sd16384, 16'sd0, 32'sd0);
    contact(cir_pkg::MODE_PEN, 4, 5, 16'sd16384, 16'sd0, 32'sh80000000);
    contact(cir_pkg::MODE_PEN, 62, 63, 16'sd16384, 16'sd0, 32'sd65536);
    contact(cir_pkg::MODE_VEL, 62, 63, 16'sh7fff, 16'sh8000, 32'sd0);
    contact(cir_pkg::MODE_PEN, 0, 4, 16'sh7fff, 16'sh8000, 32'sh7fffffff);
    contact(cir_pkg::MODE_PEN, 1, 4, 16'sh8000, 16'sh7fff, 32'sd1);
    contact(cir_pkg::MODE_VEL, 4, 5, 16'sd16384, 16'sd0, 32'sd0);
    contact(cir_pkg::MODE_VEL, 5, 4, 16'sd16384, 16'sd0, 32'sd0);
    contact(cir_pkg::MODE_VEL, 2, 3, 16'sh8000, 16'sh8000, 32'sd0);
    get_attr(0, cir_pkg::ATTR_POSX);
    get_attr(4, cir_pkg::ATTR_VELX);

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin snd_gap_max = 3; rcv_gap_max = 3; end
        1: begin set_timestep(16'hffff); snd_gap_max = 0; rcv_gap_max = 0; end
        2: begin set_timestep(16'd1); snd_gap_max = 3; rcv_gap_max = 0; end
        default: begin
          set_timestep(16'($urandom_range(1, 65535)));
          snd_gap_max = 0;
          rcv_gap_max = 3;
        end
      endcase
      for (i = 0; i < (p == 0 ? 350 : 470); i++) random_op();
      wait_idle();
    end

    $display("covered %0d writes, %0d reads, %0d penetration and %0d velocity contacts",
             mode_cnt[cir_pkg::MODE_WRITE], mode_cnt[cir_pkg::MODE_READ],
             mode_cnt[cir_pkg::MODE_PEN], mode_cnt[cir_pkg::MODE_VEL]);
    $display("outcomes: %0d done, %0d skipped, %0d same-body; four timestep settings",
             status_cnt[cir_pkg::ST_DONE], status_cnt[cir_pkg::ST_SKIP],
             status_cnt[cir_pkg::ST_SAME]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
